### hw/rtl/scp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_pkg: shared types, constants and arithmetic helpers
// Fixed-point constants for range reduction (Q.52) and the sine/cosine
// polynomials (Q.30), plus the rounding multiply and the output clamp.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int ANGLE_W = 32;   // Q8.24 input angle
    localparam int OUT_W   = 32;   // Q2.30 outputs
    localparam int RED_W   = 62;   // scaled angle plus pi, Q.52
    localparam int RES_W   = 58;   // reduced angle, Q.52
    localparam int Y_W     = 32;   // folded angle, Q.30
    localparam int POLY_W  = 34;   // polynomial datapath, Q.30
    localparam int K_W     = 7;    // turn count estimate
    localparam int T24_W   = 34;   // angle plus pi, Q.24
    localparam int EST_W   = 66;   // product for the turn estimate
    localparam int EST_SH  = 56;   // binary point of that product

    localparam logic signed [RED_W-1:0] PI_Q52     = 62'sh3243F6A8885A31;
    localparam logic signed [RED_W-1:0] TWOPI_Q52  = 62'sh6487ED5110B461;
    localparam logic signed [RED_W-1:0] HALFPI_Q52 = 62'sh1921FB54442D18;

    // pi in Q.24 (truncated) and 2^32 / (2 pi), for the turn estimate
    localparam logic signed [T24_W-1:0] PI_Q24     = 34'sh3243F6A;
    localparam logic signed [31:0]      INV_TWOPI  = 32'sd683565276;

    // pi / 2 in Q.30, rounded up
    localparam logic signed [Y_W-1:0]   HALFPI_Q30 = 32'sd1686629714;

    localparam logic signed [POLY_W-1:0] ONE_Q30 = 34'sd1073741824;

    // sine Horner coefficients, highest order first
    localparam logic signed [POLY_W-1:0] S_COEF [0:4] = '{
        34'sd2959, -34'sd213044, 34'sd8947849, -34'sd178956971, 34'sd1073739140
    };

    // cosine Horner coefficients, highest order first, ending in one
    localparam logic signed [POLY_W-1:0] C_COEF [0:4] = '{
        34'sd26631, -34'sd1491308, 34'sd44739243, -34'sd536870912, 34'sd1073741824
    };

    localparam logic signed [2*POLY_W-1:0] PROD_RND = (2*POLY_W)'(1) <<< 29;

    typedef struct packed {
        logic signed [Y_W-1:0] y30;
        logic                  neg_cos;
    } scp_item_t;

    // Q.30 times Q.30 back to Q.30, round half up
    function automatic logic signed [POLY_W-1:0] mul30(
        input logic signed [POLY_W-1:0] a,
        input logic signed [POLY_W-1:0] b
    );
        logic signed [2*POLY_W-1:0] prod;
        begin
            prod = a * b;
            prod = prod + PROD_RND;
            return prod[POLY_W+29:30];
        end
    endfunction

    // saturate to plus or minus one
    function automatic logic signed [OUT_W-1:0] clamp_one(
        input logic signed [POLY_W-1:0] v
    );
        begin
            if (v > ONE_Q30)
                return OUT_W'(ONE_Q30);
            else if (v < -ONE_Q30)
                return OUT_W'(-ONE_Q30);
            else
                return OUT_W'(v);
        end
    endfunction

endpackage
`default_nettype wire

### hw/rtl/sine_cosine_polynomial_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_core: sine and cosine of a Q8.24 angle
// Range-reduces the angle, then evaluates sine and cosine polynomials.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries one angle (signed Q8.24,
//   radians) per transaction. Output channel out_valid / out_stall returns
//   sine and cosine (signed Q2.30, saturated to plus or minus one), one
//   transaction per input, in input order.
//   From input transaction to output, an angle passes four range-reduction
//   stages, the queue and six polynomial stages ending in the output
//   register. Throughput is one transaction per cycle while out_stall is
//   low, set by the fully pipelined multiplies on both sides.
//   When the receiver stalls, the polynomial pipeline fills first, then the
//   queue of QUEUE_DEPTH entries, then the reduction stages, and only then
//   in_stall rises. Reset empties every stage and the queue; the block
//   accepts a transaction in the first cycle after reset.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  signed [scp_pkg::ANGLE_W-1:0] angle,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic signed [scp_pkg::OUT_W-1:0]   sine,
    output logic signed [scp_pkg::OUT_W-1:0]   cosine
);
    import scp_pkg::*;

    scp_item_t front_item;
    scp_item_t back_item;
    logic      front_valid;
    logic      front_ready;
    logic      back_valid;
    logic      back_ready;

    scp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .angle     (angle),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    scp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    scp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (back_valid),
        .in_ready  (back_ready),
        .in_item   (back_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sine      (sine),
        .cosine    (cosine)
    );

endmodule
`default_nettype wire

### hw/rtl/scp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_front: angle range reduction
// Four stages: turn estimate, subtract whole turns, correct into [-pi, pi),
// fold into [-pi/2, pi/2] and round to Q.30 with the cosine sign flag.
// ----------------------------------------------------------------------------
module scp_front (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire  signed [scp_pkg::ANGLE_W-1:0]  angle,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output scp_pkg::scp_item_t                  out_item
);
    import scp_pkg::*;

    localparam int NSTG = 4;

    localparam logic signed [RES_W-1:0] PI_R      = RES_W'(PI_Q52);
    localparam logic signed [RES_W-1:0] TWOPI_R   = RES_W'(TWOPI_Q52);
    localparam logic signed [RES_W-1:0] HALFPI_R  = RES_W'(HALFPI_Q52);
    localparam logic signed [RES_W-1:0] TWOPI_MPI = TWOPI_R - PI_R;
    localparam logic signed [RES_W-1:0] TWOPI_PPI = TWOPI_R + PI_R;
    localparam logic signed [RES_W-1:0] Y_RND     = RES_W'(1) <<< 21;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] load;

    logic signed [ANGLE_W-1:0] a1_reg;
    logic signed [K_W-1:0]     k1_reg;
    logic signed [K_W-1:0]     k1_next;
    logic signed [RES_W-1:0]   r0_reg;
    logic signed [RES_W-1:0]   r0_next;
    logic signed [RES_W-1:0]   x_reg;
    logic signed [RES_W-1:0]   x_next;
    scp_item_t                 item_reg;
    scp_item_t                 item_next;

    logic signed [T24_W-1:0]   t24;
    logic signed [EST_W-1:0]   est;
    logic signed [RED_W-1:0]   b_val;
    logic signed [RED_W-1:0]   turns;
    logic signed [RED_W-1:0]   diff;
    logic signed [RES_W-1:0]   y_val;
    logic signed [RES_W-1:0]   y_rnd;

    // ready chain, last stage hands off to the queue
    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        load[0]     = in_valid && rdy[0];
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            load[i]     = vld_reg[i-1] && rdy[i];
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_item  = item_reg;

    // stage 1: whole turns, off by at most one
    always_comb
    begin
        t24     = T24_W'(angle) + PI_Q24;
        est     = t24 * INV_TWOPI;
        k1_next = est[EST_SH+K_W-1:EST_SH];
    end

    // stage 2: subtract the estimated turns exactly
    always_comb
    begin
        b_val   = $signed({{(RED_W-ANGLE_W-28){a1_reg[ANGLE_W-1]}}, a1_reg, 28'd0})
                  + PI_Q52;
        turns   = k1_reg * TWOPI_Q52;
        diff    = b_val - turns;
        r0_next = diff[RES_W-1:0];
    end

    // stage 3: fix the estimate and remove the pi offset
    always_comb
    begin
        priority if (r0_reg < 0)
            x_next = r0_reg + TWOPI_MPI;
        else if (r0_reg >= TWOPI_R)
            x_next = r0_reg - TWOPI_PPI;
        else
            x_next = r0_reg - PI_R;
    end

    // stage 4: fold into the right half plane and round to Q.30
    always_comb
    begin
        item_next.neg_cos = 1'b1;
        priority if (x_reg < -HALFPI_R)
            y_val = -PI_R - x_reg;
        else if (x_reg > HALFPI_R)
            y_val = PI_R - x_reg;
        else
        begin
            y_val             = x_reg;
            item_next.neg_cos = 1'b0;
        end
        y_rnd         = y_val + Y_RND;
        item_next.y30 = y_rnd[Y_W+21:22];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            a1_reg <= angle;
            k1_reg <= k1_next;
        end
        if (load[1])
            r0_reg <= r0_next;
        if (load[2])
            x_reg <= x_next;
        if (load[3])
            item_reg <= item_next;
    end

    a_x_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (x_reg >= -PI_R) && (x_reg < PI_R))
        else $error("reduced angle outside [-pi, pi)");

    a_y_folded: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (item_reg.y30 <= HALFPI_Q30) && (item_reg.y30 >= -HALFPI_Q30))
        else $error("folded angle outside [-pi/2, pi/2]");

endmodule
`default_nettype wire

### hw/rtl/scp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_queue: short FIFO between range reduction and polynomial evaluation
// Lets either side stall without holding up the other.
// ----------------------------------------------------------------------------
module scp_queue #(
    parameter int DEPTH = 4
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  scp_pkg::scp_item_t  push_item,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output scp_pkg::scp_item_t  pop_item
);
    import scp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    scp_item_t        mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL)
        else $error("queue count above depth");

    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule
`default_nettype wire

### hw/rtl/scp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_back: polynomial evaluation
// Squares the folded angle, runs sine and cosine Horner steps side by side,
// one multiply per polynomial per stage, then applies the final sine
// multiply, cosine sign and saturation in the output register.
// ----------------------------------------------------------------------------
module scp_back (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  scp_pkg::scp_item_t                 in_item,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic signed [scp_pkg::OUT_W-1:0]   sine,
    output logic signed [scp_pkg::OUT_W-1:0]   cosine
);
    import scp_pkg::*;

    // square, four Horner steps, output
    localparam int NSTG  = 6;
    localparam int NHORN = 4;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] load;

    logic signed [POLY_W-1:0] y_reg   [0:NHORN];
    logic                     neg_reg [0:NHORN];
    logic signed [POLY_W-1:0] x2_reg  [0:NHORN-1];
    logic signed [POLY_W-1:0] sp_reg  [0:NHORN];
    logic signed [POLY_W-1:0] cp_reg  [0:NHORN];
    logic signed [POLY_W-1:0] sp_next [1:NHORN];
    logic signed [POLY_W-1:0] cp_next [1:NHORN];
    logic signed [POLY_W-1:0] y_in;
    logic signed [OUT_W-1:0]  sine_reg;
    logic signed [OUT_W-1:0]  cosine_reg;

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || !out_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        load[0]     = in_valid && rdy[0];
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            load[i]     = vld_reg[i-1] && rdy[i];
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign sine      = sine_reg;
    assign cosine    = cosine_reg;
    assign y_in      = POLY_W'(in_item.y30);

    always_comb
    begin
        for (int j = 1; j <= NHORN; j++)
        begin
            sp_next[j] = S_COEF[j] + mul30(x2_reg[j-1], sp_reg[j-1]);
            cp_next[j] = C_COEF[j] + mul30(x2_reg[j-1], cp_reg[j-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            y_reg[0]   <= y_in;
            neg_reg[0] <= in_item.neg_cos;
            x2_reg[0]  <= mul30(y_in, y_in);
            sp_reg[0]  <= S_COEF[0];
            cp_reg[0]  <= C_COEF[0];
        end
        for (int j = 1; j <= NHORN; j++)
        begin
            if (load[j])
            begin
                y_reg[j]   <= y_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                sp_reg[j]  <= sp_next[j];
                cp_reg[j]  <= cp_next[j];
            end
        end
        for (int j = 1; j < NHORN; j++)
        begin
            if (load[j])
                x2_reg[j] <= x2_reg[j-1];
        end
        if (load[NSTG-1])
        begin
            sine_reg   <= clamp_one(mul30(y_reg[NHORN], sp_reg[NHORN]));
            cosine_reg <= clamp_one(neg_reg[NHORN] ? -cp_reg[NHORN] : cp_reg[NHORN]);
        end
    end

    a_x2_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (x2_reg[0] >= 0))
        else $error("angle square negative");

    a_sine_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sine_reg <= OUT_W'(ONE_Q30)) && (sine_reg >= OUT_W'(-ONE_Q30))
                   && (cosine_reg <= OUT_W'(ONE_Q30)) && (cosine_reg >= OUT_W'(-ONE_Q30)))
        else $error("result outside plus or minus one");

endmodule
`default_nettype wire

### sim/sine_cosine_polynomial_checker.sv
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_checker: result checker for the sine/cosine core
// Watches both channels, predicts sine and cosine of every accepted angle
// with exact integer arithmetic, and compares each returned pair, in order,
// against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_checker (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    input  wire                                in_stall,
    input  wire  signed [scp_pkg::ANGLE_W-1:0] angle,
    input  wire                                out_valid,
    input  wire                                out_stall,
    input  wire  signed [scp_pkg::OUT_W-1:0]   sine,
    input  wire  signed [scp_pkg::OUT_W-1:0]   cosine,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 checked
);

    // range reduction in Q.52
    localparam longint PI_Q52     = 64'sh3243F6A8885A31;
    localparam longint TWOPI_Q52  = 64'sh6487ED5110B461;
    localparam longint HALFPI_Q52 = 64'sh1921FB54442D18;
    localparam longint UNIT_Q30   = 64'sd1073741824;

    // polynomial coefficients in Q.30
    localparam longint SIN_K1 = 64'sd1073739140;
    localparam longint SIN_K3 = -64'sd178956971;
    localparam longint SIN_K5 = 64'sd8947849;
    localparam longint SIN_K7 = -64'sd213044;
    localparam longint SIN_K9 = 64'sd2959;
    localparam longint COS_K2 = -64'sd536870912;
    localparam longint COS_K4 = 64'sd44739243;
    localparam longint COS_K6 = -64'sd1491308;
    localparam longint COS_K8 = 64'sd26631;

    typedef struct {
        logic signed [scp_pkg::ANGLE_W-1:0] angle;
        logic signed [scp_pkg::OUT_W-1:0]   sine;
        logic signed [scp_pkg::OUT_W-1:0]   cosine;
    } sincos_t;

    sincos_t expected_sincos [$];
    int      fail_total;
    int      pair_total;

    // Q.30 product back to Q.30, round half up
    function automatic longint q30_product(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint saturate_unit(longint v);
        if (v > UNIT_Q30)
            return UNIT_Q30;
        if (v < -UNIT_Q30)
            return -UNIT_Q30;
        return v;
    endfunction

    function automatic sincos_t predict_sincos(logic signed [scp_pkg::ANGLE_W-1:0] ang);
        sincos_t res;
        longint  shifted;
        longint  wrapped;
        longint  x;
        longint  y;
        longint  y30;
        longint  sq;
        longint  p;
        longint  s;
        longint  c;
        bit      flip;
        flip    = 1'b0;
        shifted = longint'(ang) * (64'sd1 <<< 28) + PI_Q52;
        // floor modulo: pull a negative remainder back into [0, 2pi)
        wrapped = shifted % TWOPI_Q52;
        if (wrapped < 0)
            wrapped = wrapped + TWOPI_Q52;
        x = wrapped - PI_Q52;
        // fold the outer quarters; the boundary itself stays unfolded
        if (x < -HALFPI_Q52)
        begin
            y    = -PI_Q52 - x;
            flip = 1'b1;
        end
        else if (x > HALFPI_Q52)
        begin
            y    = PI_Q52 - x;
            flip = 1'b1;
        end
        else
        begin
            y = x;
        end
        y30 = (y + (64'sd1 <<< 21)) >>> 22;
        sq  = q30_product(y30, y30);

        p = SIN_K9;
        p = SIN_K7 + q30_product(sq, p);
        p = SIN_K5 + q30_product(sq, p);
        p = SIN_K3 + q30_product(sq, p);
        p = SIN_K1 + q30_product(sq, p);
        s = saturate_unit(q30_product(y30, p));

        p = COS_K8;
        p = COS_K6 + q30_product(sq, p);
        p = COS_K4 + q30_product(sq, p);
        p = COS_K2 + q30_product(sq, p);
        c = UNIT_Q30 + q30_product(sq, p);
        if (flip)
            c = -c;
        c = saturate_unit(c);

        res.angle  = ang;
        res.sine   = s[scp_pkg::OUT_W-1:0];
        res.cosine = c[scp_pkg::OUT_W-1:0];
        return res;
    endfunction

    initial
    begin
        fail_total = 0;
        pair_total = 0;
    end

    always @(posedge clk)
    begin
        sincos_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_sincos.push_back(predict_sincos(angle));
            if (out_valid && !out_stall)
            begin
                if (expected_sincos.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: unexpected result transaction: sine %0d cosine %0d",
                             $time, sine, cosine);
                end
                else
                begin
                    want = expected_sincos.pop_front();
                    pair_total++;
                    if (sine !== want.sine)
                    begin
                        fail_total++;
                        $display("%0t: angle %0d: sine expected %0d, actual %0d",
                                 $time, want.angle, want.sine, sine);
                    end
                    if (cosine !== want.cosine)
                    begin
                        fail_total++;
                        $display("%0t: angle %0d: cosine expected %0d, actual %0d",
                                 $time, want.angle, want.cosine, cosine);
                    end
                end
            end
        end
        mismatches <= fail_total;
        pending    <= expected_sincos.size();
        checked    <= pair_total;
    end

endmodule

### sim/sine_cosine_polynomial_core_tb.sv
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_core_tb: testbench for the sine/cosine core
// Feeds directed edge angles, then random angles weighted toward the
// quarter- and half-turn edges, with random idling on both channels, a long
// receiver hold-off and a full drain pause. A separate checker predicts and
// compares every result pair.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_core_tb;

    localparam int RANDOM_ITEMS  = 930;
    localparam int HOLD_CYCLES   = 60;
    localparam int CALM_START    = 300;
    localparam int CALM_END      = 420;
    localparam int DRAIN_AT      = 550;
    localparam int SETTLE_CYCLES = 30;
    localparam int QUIET_LIMIT   = 2000;

    // Q8.24 landmarks
    localparam int HALF_PI_Q24 = 26353589;
    localparam int PI_Q24      = 52707178;
    localparam int TWO_PI_Q24  = 105414357;
    localparam int FOUR_PI_Q24 = 210828714;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [scp_pkg::ANGLE_W-1:0]  angle;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [scp_pkg::OUT_W-1:0]    sine;
    logic signed [scp_pkg::OUT_W-1:0]    cosine;

    int mismatches;
    int pending;
    int checked;
    int sent;
    int quiet_cycles;
    bit calm;
    bit hold_armed;
    bit hold_seen;
    int hold_left;

    sine_cosine_polynomial_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .angle     (angle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sine      (sine),
        .cosine    (cosine)
    );

    sine_cosine_polynomial_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .angle      (angle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sine       (sine),
        .cosine     (cosine),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver: random stalls, a long hold-off on request, none while calm
    initial
    begin
        out_stall    = 1'b0;
        hold_seen    = 1'b0;
        hold_left    = 0;
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_armed != hold_seen)
        begin
            hold_seen <= hold_armed;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < 38);
        end
    end

    // watchdog: end the run once nothing moves on either channel for too long
    initial
        quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("** sine_cosine_polynomial_core: FAILED **");
                $finish;
            end
        end
    end

    // offer one angle, idling at random first; hold it until accepted
    task automatic offer_angle(input logic signed [scp_pkg::ANGLE_W-1:0] value);
        while (!calm && ($urandom_range(99) < 38))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        angle    <= value;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    function automatic logic signed [scp_pkg::ANGLE_W-1:0] pick_angle();
        int kind;
        int base;
        int turns;
        kind = $urandom_range(99);
        if (kind < 30)
            return $urandom;
        if (kind < 65)
            return int'($urandom_range(2 * FOUR_PI_Q24)) - FOUR_PI_Q24;
        // land close to a fold or wrap edge, a few turns out
        case ($urandom_range(4))
            0:       base = 0;
            1:       base = HALF_PI_Q24;
            2:       base = -HALF_PI_Q24;
            3:       base = PI_Q24;
            default: base = -PI_Q24;
        endcase
        turns = int'($urandom_range(6)) - 3;
        return base + turns * TWO_PI_Q24 + int'($urandom_range(128)) - 64;
    endfunction

    initial
    begin
        logic signed [scp_pkg::ANGLE_W-1:0] edge_angles [$];
        in_valid   = 1'b0;
        angle      = '0;
        calm       = 1'b0;
        hold_armed = 1'b0;
        sent       = 0;
        edge_angles = '{
            32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sd16777216,
            HALF_PI_Q24, HALF_PI_Q24 + 1, HALF_PI_Q24 - 1,
            -HALF_PI_Q24, -HALF_PI_Q24 - 1, -HALF_PI_Q24 + 1,
            PI_Q24, PI_Q24 + 1, -PI_Q24, -PI_Q24 - 1,
            TWO_PI_Q24 - 1, TWO_PI_Q24, -TWO_PI_Q24,
            HALF_PI_Q24 + 10 * TWO_PI_Q24, -HALF_PI_Q24 - 10 * TWO_PI_Q24,
            32'sh7FFFFFFE, 32'sh80000001
        };
        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (edge_angles[i])
            offer_angle(edge_angles[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == CALM_START)
            begin
                // keep offering while the receiver holds off
                calm       <= 1'b1;
                hold_armed <= 1'b1;
            end
            if (n == CALM_END)
                calm <= 1'b0;
            if (n == DRAIN_AT)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            offer_angle(pick_angle());
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d angles (%0d at field extremes and fold/wrap edges), checked %0d pairs;",
                 sent, edge_angles.size(), checked);
        $display("random idling on both sides, a %0d-cycle output hold-off and a full drain.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("** sine_cosine_polynomial_core: PASSED **");
        else
            $display("** sine_cosine_polynomial_core: FAILED **");
        $finish;
    end

endmodule
